[sv/mnst_pkg.sv]
// Shared types, codes and constants of the MIDI note sustain tracker.
`default_nettype none
package mnst_pkg;

	// Defaults of the top-level parameters.
	localparam int NOTE_COUNT_DEF = 128;
	localparam int MAX_KEYS_DEF   = 16;

	// Time values are as wide as the time field.
	localparam int TIME_WIDTH = 32;

	// Fixed widths of the item fields.
	localparam int OPCODE_W = 3;
	localparam int NOTE_W   = 7;
	localparam int KIDX_W   = 4;
	localparam int TGT_W    = 10;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 40;

	// Event constants.
	localparam logic [6:0] SUSTAIN_CC      = 7'd64;
	localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;
	localparam logic [TGT_W-1:0] OCTAVE    = 10'd12;

	// Opcodes of an input item.
	localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_CTRL     = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_MAP_WR   = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_SUS_EN   = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE_NOTE  = 2'd0;
	localparam logic [1:0] REG_EXPAND     = 2'd1;
	localparam logic [1:0] REG_KEY_COUNT  = 2'd2;
	localparam logic [1:0] REG_REPRESS_MS = 2'd3;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		ALU_ELAPSED = 2'd0,
		ALU_FOLD_UP = 2'd1,
		ALU_FOLD_DN = 2'd2,
		ALU_NEWER   = 2'd3
	} alu_op_t;

	// Result of the shared arithmetic unit.
	typedef struct packed {
		logic                    flag;
		logic signed [TGT_W-1:0] tgt_next;
	} alu_res_t;

endpackage
`default_nettype wire

[sv/mnst_alu.sv]
// Shared arithmetic unit: elapsed-time test, octave fold steps and time compare.
`default_nettype none
module mnst_alu (
	input  wire mnst_pkg::alu_op_t                    op,
	input  wire logic [mnst_pkg::TIME_WIDTH-1:0]      time_a,
	input  wire logic [mnst_pkg::TIME_WIDTH-1:0]      time_b,
	input  wire logic [15:0]                          off_ms,
	input  wire logic signed [mnst_pkg::TGT_W-1:0]    tgt,
	input  wire logic [6:0]                           top,
	output mnst_pkg::alu_res_t                        res
);
	import mnst_pkg::*;

	logic [TIME_WIDTH-1:0] diff;

	// One subtractor serves the elapsed-time test.
	assign diff = time_a - time_b;

	always_comb begin
		res.flag     = 1'b0;
		res.tgt_next = tgt;
		unique case (op)
			ALU_ELAPSED: begin
				res.flag = diff >= TIME_WIDTH'(off_ms);
			end
			ALU_FOLD_UP: begin
				res.flag     = tgt < 0;
				res.tgt_next = tgt + $signed(OCTAVE);
			end
			ALU_FOLD_DN: begin
				res.flag     = tgt > $signed({3'b000, top});
				res.tgt_next = tgt - $signed(OCTAVE);
			end
			ALU_NEWER: begin
				res.flag = time_a > time_b;
			end
			default: begin
				res.flag = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

[sv/midi_note_sustain_tracker_core.sv]
// Top level of the MIDI note sustain tracker: note state, key map and query sequencer.
//
// Channel   Direction  Handshake          Content
// s_*       in         tvalid/tready      one event or query item
// m_*       out        tvalid/tready      one result item per key of a query
// cfg_*     in         write enable       configuration registers
//
// Note, pedal, map and enable items update the state when accepted. A query finds the top
// pitch among the keys in use, then scans all NOTE_COUNT notes: each is read and checked;
// a note that is off, hidden or out of range ends there, others go to the key match and,
// with a key hit, to the update. Folding steps the target an octave at a time before the
// match. Each result is read, then offered. The block accepts no item while a query runs.
// Reset clears all note flags at once; no clearing pass. A stalled result holds its item
// until m_tready is seen.
`default_nettype none
module midi_note_sustain_tracker_core #(
	parameter int NOTE_COUNT = mnst_pkg::NOTE_COUNT_DEF,
	parameter int MAX_KEYS   = mnst_pkg::MAX_KEYS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// opcode, note_number, control_number, control_value, key_index,
	// key_pitch, enable_flag, time_ms
	input  wire logic [mnst_pkg::IN_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// key_position, key_time
	output logic [mnst_pkg::OUT_W-1:0]      m_tdata,
	output logic                            m_tlast,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [15:0]                cfg_data
);
	import mnst_pkg::*;

	localparam int NB = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam int KB = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_INIT    = 10'b0000000010,
		ST_NRD     = 10'b0000000100,
		ST_NCHK    = 10'b0000001000,
		ST_FOLD_UP = 10'b0000010000,
		ST_FOLD_DN = 10'b0000100000,
		ST_MATCH   = 10'b0001000000,
		ST_UPD     = 10'b0010000000,
		ST_ORD     = 10'b0100000000,
		ST_OUT     = 10'b1000000000
	} state_t;

	// Input fields.
	logic [OPCODE_W-1:0]   in_opcode;
	logic [NOTE_W-1:0]     in_note;
	logic [6:0]            in_ctl;
	logic [6:0]            in_val;
	logic [KIDX_W-1:0]     in_kidx;
	logic [6:0]            in_pitch;
	logic                  in_en;
	logic [TIME_WIDTH-1:0] in_time;

	assign in_opcode = s_tdata[2:0];
	assign in_note   = s_tdata[9:3];
	assign in_ctl    = s_tdata[16:10];
	assign in_val    = s_tdata[23:17];
	assign in_kidx   = s_tdata[27:24];
	assign in_pitch  = s_tdata[34:28];
	assign in_en     = s_tdata[35];
	assign in_time   = s_tdata[67:36];

	// Configuration registers.
	logic signed [7:0] base_note_q;
	logic              expand_q;
	logic [4:0]        key_count_q;
	logic [15:0]       repress_ms_q;

	// Note state: flags in flip-flops, times in memories.
	logic [NOTE_COUNT-1:0] pt_on_q;
	logic [NOTE_COUNT-1:0] rp_on_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic [TIME_WIDTH-1:0] pt_mem [NOTE_COUNT];
	logic [TIME_WIDTH-1:0] rp_mem [NOTE_COUNT];
	logic [TIME_WIDTH-1:0] pt_rd_q;
	logic [TIME_WIDTH-1:0] rp_rd_q;

	logic pedal_q;
	logic sus_q;

	// Key map and per-key newest time.
	logic [6:0]            key_map_q [MAX_KEYS];
	logic [TIME_WIDTH-1:0] bt_mem [MAX_KEYS];
	logic [TIME_WIDTH-1:0] bt_rd_q;
	logic [MAX_KEYS-1:0]   bt_v_q;

	// Sequencer registers.
	state_t                  state_q;
	logic [NB-1:0]           n_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           cnt_q;
	logic [KB-1:0]           hk_q;
	logic [6:0]              top_q;
	logic signed [TGT_W-1:0] tgt_q;
	logic [TIME_WIDTH-1:0]   now_q;

	logic                    accept;
	logic                    note_ok;
	logic [NB-1:0]           note_idx;
	logic                    sus_pedal;
	alu_op_t                 alu_op;
	alu_res_t                alu_res;
	logic [TIME_WIDTH-1:0]   alu_a;
	logic [TIME_WIDTH-1:0]   alu_b;
	logic signed [TGT_W-1:0] tgt_start;
	logic                    hit;
	logic [KB-1:0]           hit_idx;
	logic                    last_note;
	logic                    last_out;
	logic [KB-1:0]           k_idx;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign note_ok   = {1'b0, in_note} < 8'(NOTE_COUNT);
	assign note_idx  = NB'(in_note);
	assign sus_pedal = sus_q && pedal_q;
	assign last_note = (n_q == NB'(NOTE_COUNT - 1));
	assign last_out  = (k_q + CW'(1)) == cnt_q;
	assign k_idx     = KB'(k_q);
	assign tgt_start = $signed({3'b000, 7'(n_q)}) - TGT_W'(base_note_q);

	// Shared unit operand selection.
	always_comb begin
		alu_op = ALU_ELAPSED;
		alu_a  = now_q;
		alu_b  = rp_rd_q;
		unique case (state_q)
			ST_FOLD_UP: alu_op = ALU_FOLD_UP;
			ST_FOLD_DN: alu_op = ALU_FOLD_DN;
			ST_UPD: begin
				alu_op = ALU_NEWER;
				alu_a  = pt_rd_q;
				alu_b  = bt_rd_q;
			end
			default: alu_op = ALU_ELAPSED;
		endcase
	end

	mnst_alu u_alu (
		.op     (alu_op),
		.time_a (alu_a),
		.time_b (alu_b),
		.off_ms (repress_ms_q),
		.tgt    (tgt_q),
		.top    (top_q),
		.res    (alu_res)
	);

	// First key map entry in use that equals the target.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = MAX_KEYS - 1; j >= 0; j--) begin
			if (CW'(j) < cnt_q && tgt_q == $signed({3'b000, key_map_q[j]})) begin
				hit     = 1'b1;
				hit_idx = KB'(j);
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_note_q  <= '0;
			expand_q     <= 1'b0;
			key_count_q  <= '0;
			repress_ms_q <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_NOTE:  base_note_q  <= cfg_data[7:0];
				REG_EXPAND:     expand_q     <= cfg_data[0];
				REG_KEY_COUNT:  key_count_q  <= cfg_data[4:0];
				REG_REPRESS_MS: repress_ms_q <= cfg_data;
				default:        expand_q     <= expand_q;
			endcase
		end
	end

	// Note time memories: written by note-on, read once per scanned note.
	always_ff @(posedge clk) begin
		if (accept && in_opcode == OP_NOTE_ON && note_ok) begin
			pt_mem[note_idx] <= in_time;
			rp_mem[note_idx] <= in_time;
		end
		if (state_q == ST_NRD) begin
			pt_rd_q <= pt_mem[n_q];
			rp_rd_q <= rp_mem[n_q];
		end
	end

	// Key map entries.
	always_ff @(posedge clk) begin
		if (accept && in_opcode == OP_MAP_WR && {3'b000, in_kidx} < 7'(MAX_KEYS)) begin
			key_map_q[KB'(in_kidx)] <= in_pitch;
		end
	end

	// Per-key newest time memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && (!bt_v_q[hk_q] || alu_res.flag)) begin
			bt_mem[hk_q] <= pt_rd_q;
		end
		if (state_q == ST_MATCH) begin
			bt_rd_q <= bt_mem[hit_idx];
		end else if (state_q == ST_ORD) begin
			bt_rd_q <= bt_mem[k_idx];
		end
	end

	// Event handling and query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pt_on_q <= '0;
			rp_on_q <= '0;
			held_q  <= '0;
			pedal_q <= 1'b0;
			sus_q   <= 1'b0;
			bt_v_q  <= '0;
			n_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			hk_q    <= '0;
			top_q   <= '0;
			tgt_q   <= '0;
			now_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_opcode)
							OP_NOTE_ON: begin
								if (note_ok) begin
									held_q[note_idx]  <= 1'b1;
									pt_on_q[note_idx] <= (in_time != '0);
									rp_on_q[note_idx] <= sus_pedal && pt_on_q[note_idx]
										&& (in_time != '0);
								end
							end
							OP_NOTE_OFF: begin
								if (note_ok) begin
									held_q[note_idx]  <= 1'b0;
									rp_on_q[note_idx] <= 1'b0;
									if (!(sus_pedal && pt_on_q[note_idx])) begin
										pt_on_q[note_idx] <= 1'b0;
									end
								end
							end
							OP_CTRL: begin
								if (in_ctl == SUSTAIN_CC && sus_q) begin
									pedal_q <= (in_val >= PEDAL_THRESHOLD);
									if (in_val < PEDAL_THRESHOLD) begin
										pt_on_q <= pt_on_q & held_q;
									end
								end
							end
							OP_QUERY: begin
								now_q   <= in_time;
								cnt_q   <= ({2'b00, key_count_q} > 7'(MAX_KEYS)) ?
									CW'(MAX_KEYS) : CW'(key_count_q);
								k_q     <= '0;
								top_q   <= '0;
								bt_v_q  <= '0;
								state_q <= ST_INIT;
							end
							OP_SUS_EN: begin
								sus_q <= in_en;
								if (!in_en && pedal_q) begin
									pt_on_q <= pt_on_q & held_q;
								end
							end
							default: begin
								sus_q <= sus_q;
							end
						endcase
					end
				end
				ST_INIT: begin
					// Largest pitch among the keys in use.
					if (k_q == cnt_q) begin
						n_q     <= '0;
						state_q <= ST_NRD;
					end else begin
						if (key_map_q[k_idx] > top_q) begin
							top_q <= key_map_q[k_idx];
						end
						k_q <= k_q + CW'(1);
					end
				end
				ST_NRD: begin
					state_q <= ST_NCHK;
				end
				ST_NCHK: begin
					tgt_q <= tgt_start;
					if (!pt_on_q[n_q] || (rp_on_q[n_q] && !alu_res.flag)) begin
						state_q <= ST_ORD;
						if (last_note) begin
							k_q <= '0;
							if (cnt_q == '0) begin
								state_q <= ST_IDLE;
							end
						end else begin
							n_q     <= n_q + NB'(1);
							state_q <= ST_NRD;
						end
					end else begin
						rp_on_q[n_q] <= 1'b0;
						if (expand_q) begin
							state_q <= ST_FOLD_UP;
						end else if (tgt_start < 0
								|| tgt_start > $signed({3'b000, top_q})) begin
							state_q <= ST_ORD;
							if (last_note) begin
								k_q <= '0;
								if (cnt_q == '0) begin
									state_q <= ST_IDLE;
								end
							end else begin
								n_q     <= n_q + NB'(1);
								state_q <= ST_NRD;
							end
						end else begin
							state_q <= ST_MATCH;
						end
					end
				end
				ST_FOLD_UP: begin
					if (alu_res.flag) begin
						tgt_q <= alu_res.tgt_next;
					end else begin
						state_q <= ST_FOLD_DN;
					end
				end
				ST_FOLD_DN: begin
					if (alu_res.flag) begin
						tgt_q <= alu_res.tgt_next;
					end else begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					hk_q <= hit_idx;
					if (hit) begin
						state_q <= ST_UPD;
					end else begin
						state_q <= ST_ORD;
						if (last_note) begin
							k_q <= '0;
							if (cnt_q == '0) begin
								state_q <= ST_IDLE;
							end
						end else begin
							n_q     <= n_q + NB'(1);
							state_q <= ST_NRD;
						end
					end
				end
				ST_UPD: begin
					if (!bt_v_q[hk_q] || alu_res.flag) begin
						bt_v_q[hk_q] <= 1'b1;
					end
					state_q <= ST_ORD;
					if (last_note) begin
						k_q <= '0;
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end
					end else begin
						n_q     <= n_q + NB'(1);
						state_q <= ST_NRD;
					end
				end
				ST_ORD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						if (last_out) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result item.
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = last_out;
	assign m_tdata  = {4'b0000, (bt_v_q[k_idx] ? bt_rd_q : {TIME_WIDTH{1'b0}}), 4'(k_q)};

endmodule
`default_nettype wire
